// ===== sv/rld_pkg.sv =====
// Shared types, field widths and codes for the record list block.
// Used by rld_ctrl, rld_dpath and record_list_insert_delete_sort.
package rld_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int ID_W   = 32;
  localparam int SAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CMP_W  = POS_W + 1;

  localparam int IN_BITS   = CMD_W + POS_W + ID_W + SAL_W;
  localparam int OUT_BITS  = STAT_W + POS_W + ID_W + SAL_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_POS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_ID  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOID   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SAL_W-1:0] sal;
  } rec_t;

  typedef enum logic [2:0] {I_HOLD, I_ZERO, I_CNT, I_POS, I_INC, I_DEC} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_I1, J_INC} j_op_t;
  typedef enum logic [1:0] {RA_I, RA_IM1, RA_IP1, RA_J} ra_sel_t;
  typedef enum logic {WA_I, WA_J} wa_sel_t;
  typedef enum logic [1:0] {WD_RDATA, WD_INPUT, WD_HOLD} wd_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {OI_POS, OI_I, OI_ZERO} oi_sel_t;

  typedef struct packed {
    logic              ld_in;
    i_op_t             i_op;
    j_op_t             j_op;
    logic              rd_en;
    ra_sel_t           ra_sel;
    logic              wr_en;
    wa_sel_t           wa_sel;
    wd_sel_t           wd_sel;
    logic              hold_ld;
    logic              pos_ld_i;
    cnt_op_t           cnt_op;
    logic              out_ld;
    logic [STAT_W-1:0] out_status;
    oi_sel_t           out_idx_sel;
    logic              out_entry;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cnt_zero;
    logic             cnt_full;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             i_gt_pos;
    logic             i_last;
    logic             i_end;
    logic             j_end;
    logic             id_match;
    logic             sal_le;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== sv/record_list_insert_delete_sort.sv =====
// Record list block: ordered list of id/salary records with insert,
// delete, exchange sort by salary and dump. Uses rld_pkg, rld_ctrl, rld_dpath.
//
// Usage: one command beat on the s_axis channel, results on m_axis.
// s_axis_tdata carries cmd, position, record_id, salary; m_axis_tdata
// carries status, entry_index, entry_id, entry_salary, and m_axis_tlast
// marks the final result of a command. Dump gives one beat per entry,
// or one beat for an empty list; every other command gives one beat;
// an unknown command gives none. One command is worked at a time
// through a single-port record memory with registered read data; each
// entry moved is a memory read then a write. Delete by id reads and
// compares entries up to a match, which it then deletes by position.
// Dump reads then sends each entry. Sort compares the held entry i
// with each later one (a memory read then a conditional write).
// s_axis_tready is high only while no command is in progress; it may be
// high while the last result still sits in the output register.
// When m_axis_tready is low the output register holds its beat and the
// walk pauses at the next result. Synchronous reset empties the list and
// drops any pending beat; no memory clearing is needed.
module record_list_insert_delete_sort #(
  parameter int CAPACITY = rld_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd[2:0], position[8:3], record_id[40:9], salary[72:41], zero pad
  input  logic [rld_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], entry_index[8:3], entry_id[40:9], entry_salary[72:41], zero pad
  output logic [rld_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import rld_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  rld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (dstat),
    .cmd      (dcmd)
  );

  rld_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dcmd),
    .stat      (dstat),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== sv/rld_ctrl.sv =====
// Command sequencer for the record list block.
// Drives rld_dpath through dp_cmd_t and reads back dp_stat_t; uses rld_pkg.
module rld_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rld_pkg::dp_stat_t stat,
  output rld_pkg::dp_cmd_t  cmd
);
  import rld_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RESULT,
    S_INS_CHK, S_INS_WR,
    S_DEL_CHK, S_DEL_WR,
    S_FIND_RD, S_FIND_CMP,
    S_SORT_I, S_SORT_HLD, S_SORT_J, S_SORT_CMP,
    S_DUMP_RD, S_DUMP_OUT
  } state_t;

  state_t            state, state_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  oi_sel_t           res_idx, res_idx_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_idx    <= OI_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_idx    <= res_idx_next;
    end
  end

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.cnt_full) begin
              res_status_next = ST_FULL;
              res_idx_next    = OI_POS;
              state_next      = S_RESULT;
            end else if (stat.pos_gt_cnt) begin
              res_status_next = ST_BADPOS;
              res_idx_next    = OI_POS;
              state_next      = S_RESULT;
            end else begin
              cmd.i_op   = I_CNT;
              state_next = S_INS_CHK;
            end
          end
          CMD_DEL_POS: begin
            if (stat.cnt_zero) begin
              res_status_next = ST_EMPTY;
              res_idx_next    = OI_POS;
              state_next      = S_RESULT;
            end else if (stat.pos_ge_cnt) begin
              res_status_next = ST_BADPOS;
              res_idx_next    = OI_POS;
              state_next      = S_RESULT;
            end else begin
              cmd.i_op   = I_POS;
              state_next = S_DEL_CHK;
            end
          end
          CMD_DEL_ID: begin
            if (stat.cnt_zero) begin
              res_status_next = ST_EMPTY;
              res_idx_next    = OI_ZERO;
              state_next      = S_RESULT;
            end else begin
              cmd.i_op   = I_ZERO;
              state_next = S_FIND_RD;
            end
          end
          CMD_SORT: begin
            cmd.i_op   = I_ZERO;
            state_next = S_SORT_I;
          end
          CMD_DUMP: begin
            if (stat.cnt_zero) begin
              res_status_next = ST_EMPTY;
              res_idx_next    = OI_ZERO;
              state_next      = S_RESULT;
            end else begin
              cmd.i_op   = I_ZERO;
              state_next = S_DUMP_RD;
            end
          end
          default: begin
            // unknown command: drop silently
            state_next = S_IDLE;
          end
        endcase
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_status  = res_status;
          cmd.out_idx_sel = res_idx;
          cmd.out_last    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      // insert: move entries up from the tail, then drop the new record in
      S_INS_CHK: begin
        if (stat.i_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_IM1;
          state_next = S_INS_WR;
        end else begin
          cmd.wr_en       = 1'b1;
          cmd.wa_sel      = WA_I;
          cmd.wd_sel      = WD_INPUT;
          cmd.cnt_op      = CNT_INC;
          res_status_next = ST_OK;
          res_idx_next    = OI_POS;
          state_next      = S_RESULT;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_I;
        cmd.wd_sel = WD_RDATA;
        cmd.i_op   = I_DEC;
        state_next = S_INS_CHK;
      end
      // delete: move later entries down one place
      S_DEL_CHK: begin
        if (stat.i_last) begin
          cmd.cnt_op      = CNT_DEC;
          res_status_next = ST_OK;
          res_idx_next    = OI_POS;
          state_next      = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_IP1;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_I;
        cmd.wd_sel = WD_RDATA;
        cmd.i_op   = I_INC;
        state_next = S_DEL_CHK;
      end
      S_FIND_RD: begin
        if (stat.i_end) begin
          res_status_next = ST_NOID;
          res_idx_next    = OI_ZERO;
          state_next      = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_I;
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat.id_match) begin
          cmd.pos_ld_i = 1'b1;
          state_next   = S_DEL_CHK;
        end else begin
          cmd.i_op   = I_INC;
          state_next = S_FIND_RD;
        end
      end
      // sort: entry i is held in a register while j sweeps above it
      S_SORT_I: begin
        if (stat.i_last) begin
          res_status_next = ST_OK;
          res_idx_next    = OI_ZERO;
          state_next      = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_I;
          cmd.j_op   = J_I1;
          state_next = S_SORT_HLD;
        end
      end
      S_SORT_HLD: begin
        cmd.hold_ld = 1'b1;
        state_next  = S_SORT_J;
      end
      S_SORT_J: begin
        if (stat.j_end) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_I;
          cmd.wd_sel = WD_HOLD;
          cmd.i_op   = I_INC;
          state_next = S_SORT_I;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_J;
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat.sal_le) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_J;
          cmd.wd_sel  = WD_HOLD;
          cmd.hold_ld = 1'b1;
        end
        cmd.j_op   = J_INC;
        state_next = S_SORT_J;
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = RA_I;
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_status  = ST_OK;
          cmd.out_idx_sel = OI_I;
          cmd.out_entry   = 1'b1;
          cmd.out_last    = stat.i_last;
          if (stat.i_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.i_op   = I_INC;
            state_next = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rld_dpath.sv =====
// Datapath of the record list block: record memory, count, walk indexes,
// held record and the output register. Uses rld_pkg; driven by rld_ctrl.
module rld_dpath #(
  parameter int CAPACITY = rld_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rld_pkg::dp_cmd_t              cmd,
  output rld_pkg::dp_stat_t             stat,
  input  logic [rld_pkg::S_TDATA_W-1:0] in_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rld_pkg::M_TDATA_W-1:0] out_data,
  output logic                          out_last
);
  import rld_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PAD_W = M_TDATA_W - OUT_BITS;

  rec_t mem [CAPACITY];

  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  rec_t              in_rec;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  rec_t              hold;
  rec_t              rdata;

  logic              o_valid;
  logic [STAT_W-1:0] o_status;
  logic [POS_W-1:0]  o_idx;
  rec_t              o_rec;
  logic              o_last;

  logic [CW:0]       i_inc_w;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  rec_t              wdata;

  assign i_inc_w = (CW + 1)'(i) + (CW + 1)'(1);

  always_comb begin
    unique case (cmd.ra_sel)
      RA_I:    raddr = AW'(i);
      RA_IM1:  raddr = AW'(i - 1'b1);
      RA_IP1:  raddr = AW'(i_inc_w);
      RA_J:    raddr = AW'(j);
      default: raddr = AW'(i);
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_I:    waddr = AW'(i);
      WA_J:    waddr = AW'(j);
      default: waddr = AW'(i);
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_RDATA: wdata = rdata;
      WD_INPUT: wdata = in_rec;
      WD_HOLD:  wdata = hold;
      default:  wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // input item latch and walk registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_cmd     <= in_data[CMD_W-1:0];
      in_pos     <= in_data[CMD_W +: POS_W];
      in_rec.id  <= in_data[CMD_W + POS_W +: ID_W];
      in_rec.sal <= in_data[CMD_W + POS_W + ID_W +: SAL_W];
    end else if (cmd.pos_ld_i) begin
      in_pos <= POS_W'(i);
    end
    if (cmd.hold_ld) begin
      hold <= rdata;
    end
    unique case (cmd.i_op)
      I_HOLD:  i <= i;
      I_ZERO:  i <= '0;
      I_CNT:   i <= cnt;
      I_POS:   i <= CW'(in_pos);
      I_INC:   i <= i + 1'b1;
      I_DEC:   i <= i - 1'b1;
      default: i <= i;
    endcase
    unique case (cmd.j_op)
      J_HOLD:  j <= j;
      J_I1:    j <= i_inc_w[CW-1:0];
      J_INC:   j <= j + 1'b1;
      default: j <= j;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_HOLD: cnt <= cnt;
        CNT_INC:  cnt <= cnt + 1'b1;
        CNT_DEC:  cnt <= cnt - 1'b1;
        default:  cnt <= cnt;
      endcase
    end
  end

  // output register: a result waits here while the walk goes on
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      o_status <= cmd.out_status;
      o_last   <= cmd.out_last;
      o_rec    <= cmd.out_entry ? rdata : '0;
      unique case (cmd.out_idx_sel)
        OI_POS:  o_idx <= in_pos;
        OI_I:    o_idx <= POS_W'(i);
        OI_ZERO: o_idx <= '0;
        default: o_idx <= '0;
      endcase
    end
  end

  assign out_valid = o_valid;
  assign out_last  = o_last;
  assign out_data  = {{PAD_W{1'b0}}, o_rec.sal, o_rec.id, o_idx, o_status};

  assign stat.cmd        = in_cmd;
  assign stat.cnt_zero   = (cnt == '0);
  assign stat.cnt_full   = (cnt >= CW'(CAPACITY));
  assign stat.pos_gt_cnt = (CMP_W'(in_pos) > CMP_W'(cnt));
  assign stat.pos_ge_cnt = (CMP_W'(in_pos) >= CMP_W'(cnt));
  assign stat.i_gt_pos   = (CMP_W'(i) > CMP_W'(in_pos));
  assign stat.i_last     = (i_inc_w >= (CW + 1)'(cnt));
  assign stat.i_end      = (i >= cnt);
  assign stat.j_end      = (j >= cnt);
  assign stat.id_match   = (rdata.id == in_rec.id);
  assign stat.sal_le     = (hold.sal <= rdata.sal);
  assign stat.out_free   = !o_valid || out_ready;

endmodule

// ===== tb/sv/record_list_insert_delete_sort_tb.sv =====
// Self-checking testbench for record_list_insert_delete_sort: a directed and a
// random command stream, a list predictor and a result checker on the stream ports.
// Depends on rld_pkg for field widths, command and status codes and the record type.
`timescale 1ns / 100ps

module record_list_insert_delete_sort_tb;
  import rld_pkg::*;

  localparam int LIST_CAP     = CAPACITY_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
    logic [SAL_W-1:0] sal;
    logic             drain;
  } cmd_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  index;
    logic [ID_W-1:0]   id;
    logic [SAL_W-1:0]  sal;
    logic              last;
  } result_beat_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  cmd_beat_t    cmd_queue[$];
  result_beat_t expected_results[$];
  rec_t         list_mem[LIST_CAP];
  int           list_len      = 0;
  int           err_count     = 0;
  int           total_cmds    = 0;
  int           cmds_accepted = 0;
  int           idle_cycles   = 0;
  int           gap_left      = 0;
  int           burst_left    = 8;
  int           rx_mode       = 0;
  int           rx_left       = 0;
  logic         s_fire        = 1'b0;

  record_list_insert_delete_sort #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  task automatic push_result(input logic [STAT_W-1:0] status, input logic [POS_W-1:0] index,
                             input logic [ID_W-1:0] id, input logic [SAL_W-1:0] sal,
                             input logic last);
    result_beat_t r;
    r.status = status;
    r.index  = index;
    r.id     = id;
    r.sal    = sal;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic remove_entry(input int at);
    int a;
    for (a = at; a + 1 < list_len; a++) list_mem[a] = list_mem[a + 1];
    list_len--;
  endtask

  // Apply one command to the list copy and queue the beats it should produce.
  task automatic compute_list_results(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                      input logic [ID_W-1:0] id, input logic [SAL_W-1:0] sal);
    rec_t tmp;
    int   a;
    int   b;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= LIST_CAP) begin
          push_result(ST_FULL, pos, '0, '0, 1'b1);
        end else if (int'(pos) > list_len) begin
          push_result(ST_BADPOS, pos, '0, '0, 1'b1);
        end else begin
          for (a = list_len; a > int'(pos); a--) list_mem[a] = list_mem[a - 1];
          tmp.id  = id;
          tmp.sal = sal;
          list_mem[pos] = tmp;
          list_len++;
          push_result(ST_OK, pos, '0, '0, 1'b1);
        end
      end
      CMD_DEL_POS: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, pos, '0, '0, 1'b1);
        end else if (int'(pos) >= list_len) begin
          push_result(ST_BADPOS, pos, '0, '0, 1'b1);
        end else begin
          remove_entry(int'(pos));
          push_result(ST_OK, pos, '0, '0, 1'b1);
        end
      end
      CMD_DEL_ID: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          b = -1;
          for (a = 0; a < list_len; a++) if (b < 0 && list_mem[a].id == id) b = a;
          if (b >= 0) begin
            remove_entry(b);
            push_result(ST_OK, b[POS_W-1:0], '0, '0, 1'b1);
          end else begin
            push_result(ST_NOID, '0, '0, '0, 1'b1);
          end
        end
      end
      CMD_SORT: begin
        // exchange sort, swap on less-or-equal so ties land where this loop puts them
        for (a = 0; a + 1 < list_len; a++) begin
          for (b = a + 1; b < list_len; b++) begin
            if (list_mem[a].sal <= list_mem[b].sal) begin
              tmp         = list_mem[a];
              list_mem[a] = list_mem[b];
              list_mem[b] = tmp;
            end
          end
        end
        push_result(ST_OK, '0, '0, '0, 1'b1);
      end
      CMD_DUMP: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (a = 0; a < list_len; a++)
            push_result(ST_OK, a[POS_W-1:0], list_mem[a].id, list_mem[a].sal,
                        a + 1 == list_len);
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic [ID_W-1:0] id, input logic [SAL_W-1:0] sal,
                         input logic drain);
    cmd_beat_t c;
    c.cmd   = cmd;
    c.pos   = pos;
    c.id    = id;
    c.sal   = sal;
    c.drain = drain;
    cmd_queue.push_back(c);
    total_cmds++;
  endtask

  // Mostly a small pool so deletes by id hit and duplicates occur.
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return $urandom;
    else if (r == 3) return 32'h8000_0000;
    else if (r == 4) return 32'h7fff_ffff;
    else if (r == 5) return 32'hffff_ffff;
    else return $urandom_range(0, 15);
  endfunction

  // Mostly a narrow range so the sort sees plenty of ties.
  function automatic logic [SAL_W-1:0] pick_sal();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return $urandom;
    else if (r == 6) return 32'h0000_0000;
    else if (r == 7) return 32'hffff_ffff;
    else if (r == 8) return 32'h8000_0000;
    else return $urandom_range(0, 7);
  endfunction

  initial begin : stimulus
    int k;
    int ph;
    int r;
    int pos;
    int est;
    int ins_pct;
    logic [ID_W-1:0] id;

    // directed: empty list, boundary positions, head/middle/tail, ties, unknown codes
    add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);
    add_cmd(CMD_SORT, '0, '0, '0, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd5, '0, '0, 1'b0);
    add_cmd(CMD_DEL_ID, '0, 32'd7, '0, 1'b0);
    add_cmd(CMD_INSERT, 6'd1, 32'd1, 32'd1, 1'b0);
    add_cmd(CMD_INSERT, 6'd0, 32'h8000_0000, 32'h0000_0000, 1'b0);
    add_cmd(CMD_INSERT, 6'd1, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    add_cmd(CMD_INSERT, 6'd0, 32'hffff_ffff, 32'd5, 1'b0);
    add_cmd(CMD_INSERT, 6'd1, 32'd0, 32'd5, 1'b0);
    add_cmd(CMD_INSERT, 6'd2, 32'd0, 32'd5, 1'b0);
    add_cmd(CMD_SORT, '0, '0, '0, 1'b0);
    add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);
    add_cmd(CMD_DEL_ID, '0, 32'd12345, '0, 1'b0);
    add_cmd(CMD_DEL_ID, '0, 32'd0, '0, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd63, '0, '0, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd3, '0, '0, 1'b0);
    for (k = int'(CMD_DUMP) + 1; k < (1 << CMD_W); k++)
      add_cmd(k[CMD_W-1:0], POS_W'($urandom_range(0, 63)), $urandom, $urandom, 1'b0);
    add_cmd(CMD_INSERT, 6'd63, 32'd9, 32'd9, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd0, '0, '0, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd0, '0, '0, 1'b0);
    add_cmd(CMD_SORT, '0, '0, '0, 1'b1);
    add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);
    add_cmd(CMD_DEL_POS, 6'd0, '0, '0, 1'b0);

    // fill to capacity, overfill, sort and dump the full list
    for (k = 0; k < LIST_CAP; k++)
      add_cmd(CMD_INSERT, POS_W'($urandom_range(0, k)), pick_id(), pick_sal(), 1'b0);
    for (k = 0; k < 3; k++)
      add_cmd(CMD_INSERT, POS_W'($urandom_range(0, 63)), pick_id(), pick_sal(), k == 0);
    add_cmd(CMD_SORT, '0, '0, '0, 1'b0);
    add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);

    // drain back to empty by position
    for (k = LIST_CAP; k > 0; k--) begin
      add_cmd(CMD_DEL_POS, POS_W'($urandom_range(0, k - 1)), '0, '0, 1'b0);
      if (k == LIST_CAP / 2) add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);
    end
    add_cmd(CMD_DEL_POS, POS_W'($urandom_range(0, 63)), '0, '0, 1'b0);
    add_cmd(CMD_DUMP, '0, '0, '0, 1'b0);

    // random phases: est tracks the length only roughly, misses give bad positions
    est = 0;
    for (ph = 0; ph < 6; ph++) begin
      ins_pct = (ph % 3 == 0) ? 60 : (ph % 3 == 1) ? 45 : 20;
      for (k = 0; k < 55; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          add_cmd(CMD_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 63)),
                  $urandom, $urandom, k == 0);
        end else if (r < 4 + ins_pct) begin
          pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, (est > 63) ? 63 : est);
          add_cmd(CMD_INSERT, POS_W'(pos), pick_id(), pick_sal(), k == 0);
          if (est < LIST_CAP && pos <= est) est++;
        end else begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            pos = (est == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, est - 1);
            add_cmd(CMD_DEL_POS, POS_W'(pos), '0, '0, k == 0);
            if (pos < est) est--;
          end else if (r < 7) begin
            id = pick_id();
            add_cmd(CMD_DEL_ID, POS_W'($urandom_range(0, 63)), id, $urandom, k == 0);
            if (est > 0 && id < 16) est--;
          end else if (r < 9) begin
            add_cmd(CMD_SORT, POS_W'($urandom_range(0, 63)), $urandom, $urandom, k == 0);
          end else begin
            add_cmd(CMD_DUMP, POS_W'($urandom_range(0, 63)), $urandom, $urandom, k == 0);
          end
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmds_accepted < total_cmds || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), 64'(0));
    if (err_count == 0) begin
      $display("[record_list_insert_delete_sort] OK");
    end else begin
      $display("[record_list_insert_delete_sort] ERROR");
    end
    $finish;
  end

  // Command driver: bursts of beats with random gaps; a drain beat waits for all results.
  always @(negedge clk) begin : cmd_driver
    cmd_beat_t            nxt;
    logic [S_TDATA_W-1:0] word;
    logic                 v;
    if (!rst && !(s_axis_tvalid && !s_fire)) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_queue.size() != 0 &&
                   !(cmd_queue[0].drain && expected_results.size() != 0)) begin
        nxt = cmd_queue.pop_front();
        word = '0;
        word[IN_BITS-1:0] = {nxt.sal, nxt.id, nxt.pos, nxt.cmd};
        s_axis_tdata <= word;
        v = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      s_axis_tvalid <= v;
    end
  end

  // Result sink: stall pattern changes mode every so often.
  always @(negedge clk) begin : result_sink
    logic r;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       r = 1'b1;
      1:       r = 1'($urandom_range(0, 1));
      2:       r = (rx_left % 4 == 0);
      default: r = (rx_left % 24 >= 20);
    endcase
    m_axis_tready <= r;
  end

  // Check result beats first, then predict from the command beat taken at this edge.
  always @(posedge clk) begin : check_and_predict
    result_beat_t got;
    result_beat_t want;
    if (rst) begin
      s_fire <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[STAT_W-1:0];
        got.index  = m_axis_tdata[STAT_W +: POS_W];
        got.id     = m_axis_tdata[STAT_W + POS_W +: ID_W];
        got.sal    = m_axis_tdata[STAT_W + POS_W + ID_W +: SAL_W];
        got.last   = m_axis_tlast;
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing expected, status", 64'(got.status), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.index !== want.index)
            report_mismatch("entry_index", 64'(got.index), 64'(want.index));
          if (got.id !== want.id)
            report_mismatch("entry_id", 64'(got.id), 64'(want.id));
          if (got.sal !== want.sal)
            report_mismatch("entry_salary", 64'(got.sal), 64'(want.sal));
          if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        compute_list_results(s_axis_tdata[CMD_W-1:0], s_axis_tdata[CMD_W +: POS_W],
                             s_axis_tdata[CMD_W + POS_W +: ID_W],
                             s_axis_tdata[CMD_W + POS_W + ID_W +: SAL_W]);
        cmds_accepted++;
      end
      s_fire <= s_axis_tvalid && s_axis_tready;
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("[record_list_insert_delete_sort] ERROR");
        $finish;
      end
    end
  end

endmodule
